FILE: rtl/ir_carrier_bitstream_packer_assert.svh
// Assertion macros for the IR carrier bitstream packer.
// No dependencies; included by the top level, which carries the assertions.
`ifndef IR_CARRIER_BITSTREAM_PACKER_ASSERT_SVH
`define IR_CARRIER_BITSTREAM_PACKER_ASSERT_SVH

// Same-cycle implication under synchronous reset
`define IRC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication under synchronous reset
`define IRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/irc_pkg.sv
// Shared types and constants of the IR carrier bitstream packer.
// No dependencies; used by the interfaces, the divider and the top level.
package irc_pkg;

   // Field widths
   localparam int CARRIER_W  = 20;
   localparam int CYCLE_W    = 6;
   localparam int DUR_W      = 16;
   localparam int WORD_W     = 32;
   localparam int IDX_W      = 12;
   localparam int STATUS_W   = 2;
   localparam int CLK_W      = 20;
   localparam int TIME_W     = 32;
   localparam int BT_W       = 15;
   localparam int DEN_W      = 25;
   localparam int NB_W       = 16;
   localparam int RND_W      = 17;
   localparam int POS_W      = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   // Register limits and reset values
   localparam logic [CARRIER_W-1:0] CARRIER_MIN   = 20'd1000;
   localparam logic [CARRIER_W-1:0] CARRIER_MAX   = 20'd1000000;
   localparam logic [CARRIER_W-1:0] CARRIER_RESET = 20'd38000;
   localparam logic [CYCLE_W-1:0]   CYCLE_MAX     = 6'd32;
   localparam logic [CYCLE_W-1:0]   CYCLE_RESET   = 6'd3;
   localparam logic [CYCLE_W-1:0]   HIGH_RESET    = 6'd1;
   localparam int unsigned          US_PER_S      = 1000000;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CARRIER_HZ = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CYCLE_LEN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_LEN   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT     = 2'd3;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SAT      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

   // Divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

FILE: rtl/irc_if.sv
// Valid/ready channel interfaces of the IR carrier bitstream packer.
// Depends on irc_pkg for field widths.
interface irc_req_if;
   import irc_pkg::*;
   logic             valid;
   logic             ready;
   logic [DUR_W-1:0] duration_us;
   logic             burst_end;

   modport source (output valid, duration_us, burst_end, input ready);
   modport sink   (input valid, duration_us, burst_end, output ready);
endinterface

interface irc_rsp_if;
   import irc_pkg::*;
   logic                valid;
   logic                ready;
   logic [WORD_W-1:0]   wave_word;
   logic [IDX_W-1:0]    word_index;
   logic                last;
   logic [STATUS_W-1:0] status;
   logic [CLK_W-1:0]    bit_clocks;
   logic [TIME_W-1:0]   total_time_us;

   modport source (output valid, wave_word, word_index, last, status, bit_clocks,
                   total_time_us, input ready);
   modport sink   (input valid, wave_word, word_index, last, status, bit_clocks,
                   total_time_us, output ready);
endinterface

interface irc_csr_if;
   import irc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/irc_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on irc_pkg for the status struct.
module irc_divider #(
   parameter int NUM_W = 30,
   parameter int DEN_W = 25
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [NUM_W-1:0]      num,
   input  logic [DEN_W-1:0]      den,
   output irc_pkg::div_status_type stat,
   output logic [NUM_W-1:0]      quo,
   output logic [DEN_W-1:0]      rem
);
   import irc_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   rem_shift;
   logic [DEN_W:0]   diff;

   // Shift in the next numerator bit and try a subtract
   always_comb begin
      rem_shift = {rem_ff, quo_ff[NUM_W-1]};
      diff      = rem_shift - {1'b0, den_ff};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      count_in  = count_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(NUM_W);
         quo_in   = num;
         rem_in   = '0;
         den_in   = den;
      end else if (busy_ff) begin
         if (!diff[DEN_W]) begin
            rem_in = diff[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
         quo_ff   <= quo_in;
         rem_ff   <= rem_in;
         den_ff   <= den_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quo       = quo_ff;
   assign rem       = rem_ff;

endmodule

FILE: rtl/ir_carrier_bitstream_packer.sv
// Channel     | Dir | Payload                                           | Accepted when
// req_chan    | in  | duration_us, burst_end                            | valid && ready
// rsp_chan    | out | wave_word, word_index, last, status, bit_clocks,  | valid && ready
//             |     | total_time_us                                     |
// csr_chan    | in  | index, data (carrier_hz, cycle_len, high_len, inv)| valid (ready tied high)
//
// Each request runs two divisions on the shared divider (NUM_W is 30 by default), two
// more on the first request of a burst, then packs its bits in runs (a run ends at a
// carrier edge, a word boundary or the end of the request).
// The request channel is ready only between requests. A stalled result blocks the
// run sequencer. Synchronous reset clears control state; no clearing pass is needed.
// Top level: IR pulse/space durations to a packed carrier bitstream.
// Depends on irc_pkg, irc_if and irc_divider.
`include "ir_carrier_bitstream_packer_assert.svh"

module ir_carrier_bitstream_packer #(
   parameter int MAX_WORDS     = 4096,
   parameter int MAX_ITEM_BITS = 2016,
   parameter int REF_CLOCK_HZ  = 26000000
) (
   input  logic      clock,
   input  logic      reset,
   irc_req_if.sink   req_chan,
   irc_rsp_if.source rsp_chan,
   irc_csr_if.sink   csr_chan
);
   import irc_pkg::*;

   localparam int NUM_W  = $clog2(64'(REF_CLOCK_HZ) * 64'd32 + 64'd1);
   localparam int WCNT_W = $clog2(MAX_WORDS + 1);
   localparam int RW     = $clog2(MAX_ITEM_BITS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BIT_TIME,
      ST_BIT_CLK,
      ST_NUM_BITS,
      ST_ROUND,
      ST_EMIT,
      ST_TAIL
   } state_type;

   // Sequencer and configuration
   state_type            state_ff, state_in;
   logic                 launched_ff, launched_in;
   logic [CARRIER_W-1:0] carrier_ff, carrier_in;
   logic [CYCLE_W-1:0]   cycle_ff, cycle_in;
   logic [CYCLE_W-1:0]   high_ff, high_in;
   logic                 invert_ff, invert_in;

   // Request context
   logic [DUR_W-1:0]     dur_ff, dur_in;
   logic                 end_ff, end_in;
   logic [CYCLE_W-1:0]   cyc_ff, cyc_in;
   logic [CYCLE_W-1:0]   hi_ff, hi_in;
   logic                 inv_ff, inv_in;
   logic [NB_W-1:0]      nb_ff, nb_in;
   logic                 sat_ff, sat_in;
   logic                 any_ff, any_in;
   logic [RW-1:0]        remain_ff, remain_in;
   logic [POS_W-1:0]     phase_ff, phase_in;

   // Burst state
   logic                 started_ff, started_in;
   logic [BT_W-1:0]      bit_time_ff, bit_time_in;
   logic [CLK_W-1:0]     clocks_ff, clocks_in;
   logic [TIME_W-1:0]    time_sum_ff, time_sum_in;
   logic                 space_ff, space_in;
   logic [WCNT_W-1:0]    words_ff, words_in;
   logic [WORD_W-1:0]    accum_ff, accum_in;
   logic [POS_W-1:0]     bit_pos_ff, bit_pos_in;

   // Result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]    rsp_word_ff, rsp_word_in;
   logic [IDX_W-1:0]     rsp_index_ff, rsp_index_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [CLK_W-1:0]     rsp_clocks_ff, rsp_clocks_in;
   logic [TIME_W-1:0]    rsp_total_ff, rsp_total_in;

   // Effective register values
   logic [CARRIER_W-1:0] car_eff;
   logic [CYCLE_W-1:0]   cyc_eff;
   logic [CYCLE_W-1:0]   hi_eff;

   // Divider hookup
   logic                    div_start;
   logic [NUM_W-1:0]        div_num;
   logic [DEN_W-1:0]        div_den;
   irc_pkg::div_status_type div_stat;
   logic [NUM_W-1:0]        div_quo;
   logic [DEN_W-1:0]        div_rem;
   logic [NUM_W:0]          div_ceil;
   logic [RND_W-1:0]        rounded;

   // Run datapath
   logic                 out_free;
   logic                 in_high;
   logic                 run_bit;
   logic [RW-1:0]        run_left;
   logic [RW-1:0]        room;
   logic [RW-1:0]        len_wide;
   logic [CYCLE_W-1:0]   len;
   logic [WORD_W-1:0]    run_mask;
   logic [WORD_W-1:0]    acc_new;
   logic [CYCLE_W-1:0]   pos_sum;
   logic [CYCLE_W-1:0]   ph_sum;
   logic [RW-1:0]        remain_next;
   logic [TIME_W:0]      time_add;
   logic                 need_tail;

   // Result builder
   logic                 put_fire;
   logic [WORD_W-1:0]    put_word;
   logic                 put_last;
   logic                 overflow;
   logic [WCNT_W-1:0]    put_index;

   // Clamp registers into their legal ranges
   always_comb begin
      car_eff = carrier_ff;
      if (carrier_ff < CARRIER_MIN) car_eff = CARRIER_MIN;
      if (carrier_ff > CARRIER_MAX) car_eff = CARRIER_MAX;
      cyc_eff = cycle_ff;
      if (cycle_ff == '0) cyc_eff = CYCLE_W'(1);
      if (cycle_ff > CYCLE_MAX) cyc_eff = CYCLE_MAX;
      hi_eff = high_ff;
      if (high_ff == '0) hi_eff = CYCLE_W'(1);
      if (high_ff > cyc_eff) hi_eff = cyc_eff;
   end

   // Select divider operands for the current step
   always_comb begin
      case (state_ff)
         ST_BIT_TIME: begin
            div_num = NUM_W'(32'(US_PER_S) * 32'(hi_ff));
            div_den = DEN_W'(26'(car_eff) * 26'(cyc_ff));
         end
         ST_BIT_CLK: begin
            div_num = NUM_W'(64'(REF_CLOCK_HZ) * 64'(hi_ff));
            div_den = DEN_W'(26'(car_eff) * 26'(cyc_ff));
         end
         ST_NUM_BITS: begin
            div_num = NUM_W'(dur_ff);
            div_den = DEN_W'(bit_time_ff);
         end
         ST_ROUND: begin
            div_num = NUM_W'(nb_ff);
            div_den = DEN_W'(cyc_ff);
         end
         default: begin
            div_num = '0;
            div_den = '0;
         end
      endcase
   end

   assign div_ceil = (NUM_W+1)'(div_quo) + (NUM_W+1)'(div_rem != '0);
   assign rounded  = (div_rem == '0) ? RND_W'(nb_ff)
                   : RND_W'(nb_ff) + RND_W'(cyc_ff) - RND_W'(div_rem);

   // Size the next bit run: carrier edge, word end or request end
   always_comb begin
      out_free = !rsp_valid_ff || rsp_chan.ready;
      in_high  = !space_ff && (CYCLE_W'(phase_ff) < hi_ff);
      run_bit  = in_high ^ inv_ff;
      if (space_ff) run_left = remain_ff;
      else if (in_high) run_left = RW'(hi_ff - CYCLE_W'(phase_ff));
      else run_left = RW'(cyc_ff - CYCLE_W'(phase_ff));
      room     = RW'(CYCLE_W'(WORD_W) - CYCLE_W'(bit_pos_ff));
      len_wide = (run_left < room) ? run_left : room;
      if (remain_ff < len_wide) len_wide = remain_ff;
      len         = CYCLE_W'(len_wide);
      run_mask    = WORD_W'(~(64'hFFFF_FFFF_FFFF_FFFF << len)) << bit_pos_ff;
      acc_new     = accum_ff | (run_bit ? run_mask : '0);
      pos_sum     = CYCLE_W'(bit_pos_ff) + len;
      ph_sum      = CYCLE_W'(phase_ff) + len;
      remain_next = remain_ff - len_wide;
      time_add    = (TIME_W+1)'(time_sum_ff) + (TIME_W+1)'(req_chan.duration_us);
      need_tail   = (bit_pos_ff != '0) || !any_ff;
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      launched_in   = launched_ff;
      carrier_in    = carrier_ff;
      cycle_in      = cycle_ff;
      high_in       = high_ff;
      invert_in     = invert_ff;
      dur_in        = dur_ff;
      end_in        = end_ff;
      cyc_in        = cyc_ff;
      hi_in         = hi_ff;
      inv_in        = inv_ff;
      nb_in         = nb_ff;
      sat_in        = sat_ff;
      any_in        = any_ff;
      remain_in     = remain_ff;
      phase_in      = phase_ff;
      started_in    = started_ff;
      bit_time_in   = bit_time_ff;
      clocks_in     = clocks_ff;
      time_sum_in   = time_sum_ff;
      space_in      = space_ff;
      words_in      = words_ff;
      accum_in      = accum_ff;
      bit_pos_in    = bit_pos_ff;
      div_start     = 1'b0;
      put_fire      = 1'b0;
      put_word      = accum_ff;
      put_last      = 1'b0;

      // Take register writes
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_CARRIER_HZ: carrier_in = csr_chan.data[CARRIER_W-1:0];
            CSR_CYCLE_LEN:  cycle_in   = csr_chan.data[CYCLE_W-1:0];
            CSR_HIGH_LEN:   high_in    = csr_chan.data[CYCLE_W-1:0];
            CSR_INVERT:     invert_in  = csr_chan.data[0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               dur_in      = req_chan.duration_us;
               end_in      = req_chan.burst_end;
               cyc_in      = cyc_eff;
               hi_in       = hi_eff;
               inv_in      = invert_ff;
               time_sum_in = time_add[TIME_W] ? '1 : time_add[TIME_W-1:0];
               state_in    = started_ff ? ST_NUM_BITS : ST_BIT_TIME;
            end
         end
         ST_BIT_TIME, ST_BIT_CLK, ST_NUM_BITS, ST_ROUND: begin
            if (!launched_ff) begin
               div_start   = 1'b1;
               launched_in = 1'b1;
            end else if (div_stat.done) begin
               launched_in = 1'b0;
               case (state_ff)
                  ST_BIT_TIME: begin
                     bit_time_in = (div_ceil[BT_W-1:0] == '0) ? BT_W'(1)
                                 : div_ceil[BT_W-1:0];
                     state_in    = ST_BIT_CLK;
                  end
                  ST_BIT_CLK: begin
                     clocks_in  = CLK_W'(div_ceil - 1'b1);
                     started_in = 1'b1;
                     state_in   = ST_NUM_BITS;
                  end
                  ST_NUM_BITS: begin
                     nb_in    = div_ceil[NB_W-1:0];
                     state_in = ST_ROUND;
                  end
                  default: begin
                     if (rounded > RND_W'(MAX_ITEM_BITS)) begin
                        remain_in = RW'(MAX_ITEM_BITS);
                        sat_in    = 1'b1;
                     end else begin
                        remain_in = RW'(rounded);
                        sat_in    = 1'b0;
                     end
                     phase_in = '0;
                     any_in   = 1'b0;
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end
         ST_EMIT: begin
            if (remain_ff == '0) begin
               state_in = ST_TAIL;
            end else if (out_free) begin
               remain_in = remain_next;
               phase_in  = (ph_sum == cyc_ff) ? '0 : ph_sum[POS_W-1:0];
               if (pos_sum[CYCLE_W-1]) begin
                  // Word full: push it out
                  put_fire   = 1'b1;
                  put_word   = acc_new;
                  put_last   = end_ff && (remain_next == '0);
                  any_in     = 1'b1;
                  accum_in   = '0;
                  bit_pos_in = '0;
               end else begin
                  accum_in   = acc_new;
                  bit_pos_in = pos_sum[POS_W-1:0];
               end
            end
         end
         ST_TAIL: begin
            if (!end_ff) begin
               space_in = !space_ff;
               state_in = ST_IDLE;
            end else if (!need_tail || out_free) begin
               // Flush the partial word, then drop burst state
               put_fire    = need_tail;
               put_word    = accum_ff;
               put_last    = 1'b1;
               accum_in    = '0;
               bit_pos_in  = '0;
               space_in    = 1'b0;
               time_sum_in = '0;
               bit_time_in = '0;
               clocks_in   = '0;
               started_in  = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // Count words; past the buffer, hold the count
      if (put_fire && !overflow) words_in = words_ff + 1'b1;
      if (state_ff == ST_TAIL && end_ff && (!need_tail || out_free)) words_in = '0;
   end

   // Build the result, replacing words past the buffer
   always_comb begin
      overflow  = words_ff >= WCNT_W'(MAX_WORDS);
      put_index = overflow ? WCNT_W'(MAX_WORDS - 1) : words_ff;
      rsp_valid_in  = put_fire ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
      rsp_word_in   = rsp_word_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      rsp_clocks_in = rsp_clocks_ff;
      rsp_total_in  = rsp_total_ff;
      if (put_fire) begin
         rsp_word_in   = overflow ? '0 : put_word;
         rsp_index_in  = IDX_W'(put_index);
         rsp_last_in   = put_last;
         rsp_status_in = overflow ? STATUS_OVERFLOW : (sat_ff ? STATUS_SAT : STATUS_OK);
         rsp_clocks_in = clocks_ff;
         rsp_total_in  = put_last ? time_sum_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launched_ff  <= 1'b0;
         carrier_ff   <= CARRIER_RESET;
         cycle_ff     <= CYCLE_RESET;
         high_ff      <= HIGH_RESET;
         invert_ff    <= 1'b0;
         started_ff   <= 1'b0;
         bit_time_ff  <= '0;
         clocks_ff    <= '0;
         time_sum_ff  <= '0;
         space_ff     <= 1'b0;
         words_ff     <= '0;
         accum_ff     <= '0;
         bit_pos_ff   <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         launched_ff   <= launched_in;
         carrier_ff    <= carrier_in;
         cycle_ff      <= cycle_in;
         high_ff       <= high_in;
         invert_ff     <= invert_in;
         dur_ff        <= dur_in;
         end_ff        <= end_in;
         cyc_ff        <= cyc_in;
         hi_ff         <= hi_in;
         inv_ff        <= inv_in;
         nb_ff         <= nb_in;
         sat_ff        <= sat_in;
         any_ff        <= any_in;
         remain_ff     <= remain_in;
         phase_ff      <= phase_in;
         started_ff    <= started_in;
         bit_time_ff   <= bit_time_in;
         clocks_ff     <= clocks_in;
         time_sum_ff   <= time_sum_in;
         space_ff      <= space_in;
         words_ff      <= words_in;
         accum_ff      <= accum_in;
         bit_pos_ff    <= bit_pos_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_word_ff   <= rsp_word_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_status_ff <= rsp_status_in;
         rsp_clocks_ff <= rsp_clocks_in;
         rsp_total_ff  <= rsp_total_in;
      end
   end

   irc_divider #(
      .NUM_W(NUM_W),
      .DEN_W(DEN_W)
   ) u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .stat  (div_stat),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   // Drive the channels
   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign csr_chan.ready         = 1'b1;
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.wave_word     = rsp_word_ff;
   assign rsp_chan.word_index    = rsp_index_ff;
   assign rsp_chan.last          = rsp_last_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.bit_clocks    = rsp_clocks_ff;
   assign rsp_chan.total_time_us = rsp_total_ff;

   // Checks
   `IRC_ASSERT_IMPL(a_overflow_zero, clock, reset,
      rsp_valid_ff && rsp_status_ff == STATUS_OVERFLOW, rsp_word_ff == '0,
      "dropped word carries data")
   `IRC_ASSERT_IMPL(a_time_on_last, clock, reset,
      rsp_valid_ff && !rsp_last_ff, rsp_total_ff == '0,
      "total time on a non-final word")
   `IRC_ASSERT_IMPL(a_div_idle, clock, reset,
      div_start, !div_stat.busy,
      "divider restarted while busy")
   `IRC_ASSERT_NEXT(a_run_progress, clock, reset,
      state_ff == ST_EMIT && out_free && remain_ff != '0, remain_ff < $past(remain_ff),
      "bit run made no progress")

endmodule

FILE: dv/ir_carrier_bitstream_packer_test.sv
// Testbench for the IR carrier bitstream packer: directed and random bursts, checked word
// by word against a predictor kept in a small scoreboard class.
// Depends on irc_pkg, the irc_if channel interfaces and ir_carrier_bitstream_packer.
module ir_carrier_bitstream_packer_test;
   import irc_pkg::*;

   localparam int WORD_LIMIT     = 4096;
   localparam int ITEM_BIT_LIMIT = 2016;
   localparam int REF_HZ         = 26000000;
   localparam int RANDOM_ITEMS   = 200;
   localparam int SETTLE_CYCLES  = 300;
   localparam int OVERFLOW_ITEMS = 70;

   logic clock;
   logic reset;

   irc_req_if req_bus ();
   irc_rsp_if rsp_bus ();
   irc_csr_if csr_bus ();

   ir_carrier_bitstream_packer #(
      .MAX_WORDS     (WORD_LIMIT),
      .MAX_ITEM_BITS (ITEM_BIT_LIMIT),
      .REF_CLOCK_HZ  (REF_HZ)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   typedef struct packed {
      logic [WORD_W-1:0]   wave_word;
      logic [IDX_W-1:0]    word_index;
      logic                last;
      logic [STATUS_W-1:0] status;
      logic [CLK_W-1:0]    bit_clocks;
      logic [TIME_W-1:0]   total_time_us;
   } wave_result_type;

   // Packs the carrier waveform of each request and holds the words still owed
   class wave_word_predictor;
      logic [CARRIER_W-1:0] carrier_reg;
      logic [CYCLE_W-1:0]   cycle_reg;
      logic [CYCLE_W-1:0]   high_reg;
      logic                 invert_reg;
      logic [WORD_W-1:0]    accum;
      int unsigned          fill;
      int unsigned          words_out;
      bit                   in_space;
      bit                   burst_open;
      logic [TIME_W-1:0]    time_sum;
      int unsigned          bit_time_us;
      logic [CLK_W-1:0]     clocks_per_bit;
      wave_result_type      pending_words[$];
      int                   mismatches;
      int                   words_checked;
      int                   requests_seen;
      int                   bursts_seen;
      int                   sat_words;
      int                   dropped_words;
      int                   reg_writes;

      function new();
         carrier_reg   = CARRIER_RESET;
         cycle_reg     = CYCLE_RESET;
         high_reg      = HIGH_RESET;
         invert_reg    = 1'b0;
         mismatches    = 0;
         words_checked = 0;
         requests_seen = 0;
         bursts_seen   = 0;
         sat_words     = 0;
         dropped_words = 0;
         reg_writes    = 0;
         clear_burst();
      endfunction

      function void clear_burst();
         accum          = '0;
         fill           = 0;
         words_out      = 0;
         in_space       = 1'b0;
         time_sum       = '0;
         bit_time_us    = 0;
         clocks_per_bit = '0;
         burst_open     = 1'b0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         reg_writes++;
         case (idx)
            CSR_CARRIER_HZ: carrier_reg = value;
            CSR_CYCLE_LEN:  cycle_reg   = value[CYCLE_W-1:0];
            CSR_HIGH_LEN:   high_reg    = value[CYCLE_W-1:0];
            CSR_INVERT:     invert_reg  = value[0];
            default: ;
         endcase
      endfunction

      // Queue one word; past the buffer end it becomes a dropped-word marker
      function void push_word(logic [WORD_W-1:0] word, logic [STATUS_W-1:0] stat,
                              bit is_last);
         wave_result_type r;
         if (words_out >= WORD_LIMIT) begin
            r.wave_word  = '0;
            r.word_index = IDX_W'(WORD_LIMIT - 1);
            r.status     = STATUS_OVERFLOW;
         end else begin
            r.wave_word  = word;
            r.word_index = IDX_W'(words_out);
            r.status     = stat;
            words_out++;
         end
         r.last          = is_last;
         r.bit_clocks    = clocks_per_bit;
         r.total_time_us = is_last ? time_sum : '0;
         pending_words.push_back(r);
      endfunction

      function void note_request(logic [DUR_W-1:0] dur, logic burst_end);
         int unsigned         cyc;
         int unsigned         hi;
         int unsigned         car;
         int unsigned         nbits;
         int unsigned         produced;
         longint unsigned     den;
         longint unsigned     num;
         logic [STATUS_W-1:0] stat;
         logic                wave_bit;
         wave_result_type     tail;
         requests_seen++;
         cyc = cycle_reg;
         if (cyc < 1) cyc = 1;
         if (cyc > CYCLE_MAX) cyc = CYCLE_MAX;
         hi = high_reg;
         if (hi < 1) hi = 1;
         if (hi > cyc) hi = cyc;

         // Latch bit time and clocks per bit on the first request of a burst
         if (!burst_open) begin
            car = carrier_reg;
            if (car < CARRIER_MIN) car = CARRIER_MIN;
            if (car > CARRIER_MAX) car = CARRIER_MAX;
            den = longint'(car) * longint'(cyc);
            num = longint'(US_PER_S) * longint'(hi);
            bit_time_us = int'((num + den - 1) / den) & 32'h7FFF;
            if (bit_time_us == 0) bit_time_us = 1;
            num = longint'(REF_HZ) * longint'(hi);
            clocks_per_bit = CLK_W'((num + den - 1) / den - 1);
            burst_open = 1'b1;
         end

         // Saturate the burst time
         if (longint'(time_sum) + longint'(dur) > 64'hFFFF_FFFF) time_sum = '1;
         else time_sum = time_sum + dur;

         // Round bit count up to whole carrier cycles, then clip
         nbits = (dur + bit_time_us - 1) / bit_time_us;
         nbits = ((nbits + cyc - 1) / cyc) * cyc;
         stat  = STATUS_OK;
         if (nbits > ITEM_BIT_LIMIT) begin
            nbits = ITEM_BIT_LIMIT;
            stat  = STATUS_SAT;
         end

         produced = 0;
         for (int unsigned j = 0; j < nbits; j++) begin
            wave_bit    = (!in_space && ((j % cyc) < hi)) ^ invert_reg;
            accum[fill] = wave_bit;
            fill++;
            if (fill == WORD_W) begin
               push_word(accum, stat, 1'b0);
               produced++;
               accum = '0;
               fill  = 0;
            end
         end
         in_space = !in_space;

         // Flush a partial or empty tail, or mark the last full word
         if (burst_end) begin
            bursts_seen++;
            if (fill > 0 || produced == 0) begin
               push_word(accum, stat, 1'b1);
            end else begin
               tail               = pending_words.pop_back();
               tail.last          = 1'b1;
               tail.total_time_us = time_sum;
               pending_words.push_back(tail);
            end
            clear_burst();
         end
      endfunction

      function void compare_field(string field_name, longint unsigned want,
                                  longint unsigned got);
         if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, field_name, want, got);
         end
      endfunction

      function void check_word(wave_result_type got);
         wave_result_type want;
         if (pending_words.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result word 0x%08h at index %0d",
                     $time, got.wave_word, got.word_index);
         end else begin
            want = pending_words.pop_front();
            words_checked++;
            if (want.status == STATUS_SAT) sat_words++;
            if (want.status == STATUS_OVERFLOW) dropped_words++;
            compare_field("wave_word", want.wave_word, got.wave_word);
            compare_field("word_index", want.word_index, got.word_index);
            compare_field("last", want.last, got.last);
            compare_field("status", want.status, got.status);
            compare_field("bit_clocks", want.bit_clocks, got.bit_clocks);
            compare_field("total_time_us", want.total_time_us, got.total_time_us);
         end
      endfunction
   endclass

   wave_word_predictor predictor;
   bit                 req_gaps_on;
   bit                 rsp_stalls_on;
   int                 random_items;

   // Free-running clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Mostly no gap, often a short one, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [DUR_W-1:0] pick_duration();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         case ($urandom_range(0, 3))
            0: return '0;
            1: return DUR_W'(1);
            2: return '1;
            default: return DUR_W'(16'hFFFE);
         endcase
      end
      if (r < 65) return DUR_W'($urandom_range(0, 1500));
      if (r < 90) return DUR_W'($urandom_range(0, 12000));
      return DUR_W'($urandom);
   endfunction

   // Observe all three channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready)
            predictor.write_reg(csr_bus.index, csr_bus.data);
         if (req_bus.valid && req_bus.ready)
            predictor.note_request(req_bus.duration_us, req_bus.burst_end);
         if (rsp_bus.valid && rsp_bus.ready)
            predictor.check_word('{rsp_bus.wave_word, rsp_bus.word_index, rsp_bus.last,
                                   rsp_bus.status, rsp_bus.bit_clocks,
                                   rsp_bus.total_time_us});
      end
   end

   // Stall the result channel in random runs
   initial begin
      int stall_left;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (rsp_stalls_on) stall_left = pick_gap();
         end
      end
   end

   // Send one request after an optional gap and hold it until accepted
   task automatic send_request(input logic [DUR_W-1:0] dur, input logic end_flag);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid       <= 1'b1;
      req_bus.duration_us <= dur;
      req_bus.burst_end   <= end_flag;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   // Write all four registers; junk in the unused upper data bits
   task automatic program_regs(input logic [CARRIER_W-1:0] car,
                               input logic [CYCLE_W-1:0] cyc,
                               input logic [CYCLE_W-1:0] hi,
                               input logic inv);
      write_reg(CSR_CARRIER_HZ, car);
      write_reg(CSR_CYCLE_LEN, {(CSR_DATA_W-CYCLE_W)'($urandom), cyc});
      write_reg(CSR_HIGH_LEN, {(CSR_DATA_W-CYCLE_W)'($urandom), hi});
      write_reg(CSR_INVERT, {(CSR_DATA_W-1)'($urandom), inv});
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic program_random_regs();
      logic [CARRIER_W-1:0] car;
      logic [CYCLE_W-1:0]   cyc;
      logic [CYCLE_W-1:0]   hi;
      int                   hi_top;
      case ($urandom_range(0, 5))
         0: car = CARRIER_MIN;
         1: car = CARRIER_MAX;
         2: car = CARRIER_W'($urandom);
         default: car = CARRIER_W'($urandom_range(1000, 1000000));
      endcase
      if ($urandom_range(0, 7) == 0) cyc = CYCLE_W'($urandom);
      else cyc = CYCLE_W'($urandom_range(1, 32));
      hi_top = (cyc == 0) ? 1 : ((cyc > CYCLE_MAX) ? CYCLE_MAX : cyc);
      if ($urandom_range(0, 7) == 0) hi = CYCLE_W'($urandom);
      else hi = CYCLE_W'($urandom_range(1, hi_top));
      program_regs(car, cyc, hi, 1'($urandom_range(0, 1)));
   endtask

   // Hold off requests until every owed word is back and the block has settled
   task automatic drain_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (predictor.pending_words.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Random burst; now and then end it early
   task automatic run_burst(input int n_items);
      logic end_flag;
      for (int k = 0; k < n_items; k++) begin
         end_flag = (k == n_items - 1) || ($urandom_range(0, 39) == 0);
         send_request(pick_duration(), end_flag);
         random_items++;
      end
   endtask

   initial begin
      int phase;
      predictor           = new();
      req_gaps_on         = 1'b1;
      rsp_stalls_on       = 1'b1;
      random_items        = 0;
      req_bus.valid       = 1'b0;
      req_bus.duration_us = '0;
      req_bus.burst_end   = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = CSR_CARRIER_HZ;
      csr_bus.data        = '0;
      reset               = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset settings: empty burst gives one zero word, then a clipped pulse
      send_request('0, 1'b1);
      send_request('1, 1'b0);
      send_request(DUR_W'(1), 1'b0);
      send_request(DUR_W'(100), 1'b1);

      // One-microsecond bits: word-aligned tails mark the last full word
      drain_results();
      program_regs(CARRIER_MAX, CYCLE_W'(1), CYCLE_W'(1), 1'b0);
      send_request(DUR_W'(32), 1'b1);
      send_request(DUR_W'(32), 1'b0);
      send_request(DUR_W'(32), 1'b1);

      // Change registers mid-burst: bit time stays latched, shape follows live
      drain_results();
      program_regs(CARRIER_RESET, CYCLE_RESET, HIGH_RESET, 1'b0);
      send_request(DUR_W'(500), 1'b0);
      drain_results();
      program_regs(CARRIER_MIN, CYCLE_W'(5), CYCLE_W'(2), 1'b1);
      send_request(DUR_W'(700), 1'b0);
      send_request('1, 1'b1);

      // Registers below range clamp up
      drain_results();
      program_regs('0, '0, '0, 1'b1);
      send_request(DUR_W'(1), 1'b0);
      send_request(DUR_W'(16'hFFFE), 1'b0);
      send_request(DUR_W'(3000), 1'b1);

      // Registers above range clamp down
      drain_results();
      program_regs('1, '1, '1, 1'b0);
      send_request('1, 1'b0);
      send_request(DUR_W'(2), 1'b0);
      send_request(DUR_W'(777), 1'b1);

      // High length above cycle length, cycle length not a power of two
      drain_results();
      program_regs(CARRIER_MIN, CYCLE_W'(7), CYCLE_W'(20), 1'b0);
      send_request(DUR_W'(5000), 1'b0);
      send_request(DUR_W'(4321), 1'b1);
      drain_results();
      program_regs(CARRIER_W'(56000), CYCLE_W'(5), CYCLE_W'(3), 1'b1);
      send_request(DUR_W'(1234), 1'b0);
      send_request(DUR_W'(999), 1'b0);
      send_request(DUR_W'(31), 1'b1);

      // Random phases, one of them overflowing the word buffer
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         drain_results();
         if (phase == 2) begin
            req_gaps_on   = 1'b1;
            rsp_stalls_on = 1'($urandom_range(0, 1));
            program_regs(CARRIER_MAX, CYCLE_MAX, CYCLE_MAX, 1'($urandom_range(0, 1)));
            for (int k = 0; k < OVERFLOW_ITEMS; k++) begin
               send_request(DUR_W'($urandom_range(2100, 65535)), k == OVERFLOW_ITEMS - 1);
               random_items++;
            end
         end else begin
            req_gaps_on   = $urandom_range(0, 3) != 0;
            rsp_stalls_on = $urandom_range(0, 3) != 0;
            program_random_regs();
            repeat ($urandom_range(1, 3)) begin
               run_burst($urandom_range(1, 8));
               if ($urandom_range(0, 3) == 0) drain_results();
            end
         end
         phase++;
      end

      drain_results();
      $display("Covered %0d requests in %0d bursts, %0d result words, %0d register writes",
               predictor.requests_seen, predictor.bursts_seen, predictor.words_checked,
               predictor.reg_writes);
      $display("Words from clipped requests: %0d, dropped past buffer end: %0d",
               predictor.sat_words, predictor.dropped_words);
      if (predictor.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #50_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
